FILE: rtl/generational_handle_allocator_macros.svh
// Assertion macros for the generational handle allocator checker.
// Depends on signals named clk and arst_n in the scope of each use.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_MACROS_SVH

// cond in a cycle implies expr in the same cycle
`define GHA_ASSERT_IMPL(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error("allocator port check failed");

// cond in a cycle implies expr in the next cycle
`define GHA_ASSERT_NEXT(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("allocator port check failed");

`endif

FILE: rtl/gha_pkg.sv
// Shared constants for the generational handle allocator.
// No dependencies.
package gha_pkg;

	localparam int SLOTS_DEFAULT = 1024;
	localparam int GEN_W         = 32;
	localparam int FUNC_W        = 2;
	localparam int STATUS_W      = 2;

	// operation codes
	localparam logic [FUNC_W-1:0] OP_ALLOC   = 2'd0;
	localparam logic [FUNC_W-1:0] OP_RELEASE = 2'd1;
	localparam logic [FUNC_W-1:0] OP_CHECK   = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DEAD = 2'd2;

endpackage

FILE: rtl/gha_req_if.sv
// Request channel of the handle allocator: valid/ready plus operation payload.
// Depends on gha_pkg.
interface gha_req_if #(
	parameter int IDX_W = 10
);
	logic                        valid;
	logic                        ready;
	logic [gha_pkg::FUNC_W-1:0]  func;
	logic [IDX_W-1:0]            handle_index;
	logic [gha_pkg::GEN_W-1:0]   handle_generation;

	modport source (output valid, func, handle_index, handle_generation, input ready);
	modport sink   (input valid, func, handle_index, handle_generation, output ready);
endinterface

FILE: rtl/gha_rsp_if.sv
// Response channel of the handle allocator: valid/ready plus result payload.
// Depends on gha_pkg.
interface gha_rsp_if #(
	parameter int IDX_W = 10,
	parameter int CNT_W = 11
);
	logic                          valid;
	logic                          ready;
	logic [gha_pkg::STATUS_W-1:0]  status;
	logic [IDX_W-1:0]              slot_index;
	logic [gha_pkg::GEN_W-1:0]     slot_generation;
	logic [CNT_W-1:0]              live_total;

	modport source (output valid, status, slot_index, slot_generation, live_total,
		input ready);
	modport sink   (input valid, status, slot_index, slot_generation, live_total,
		output ready);
endinterface

FILE: rtl/generational_handle_allocator.sv
// Steps: accept with the free-stack read, address with the slot-table read, then execute.
// A new request waits until the last commits; the free-stack read must finish before
// the slot-table read can be addressed, and the slot table is then read-modify-written.
// A stalled response holds the block in its execute step until taken.
// Reset clears the counters and state; the memories are not cleared, the high-water
// mark and free-stack top keep unwritten entries from being used (no clearing pass).
module generational_handle_allocator #(
	parameter int SLOTS = gha_pkg::SLOTS_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	gha_req_if.sink      req,
	gha_rsp_if.source    rsp
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int GEN_W = gha_pkg::GEN_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ADDR,
		S_EXEC
	} state_t;

	state_t state_q;

	// {used, generation} per slot, and the LIFO of freed indexes
	logic [GEN_W:0]   slot_mem  [SLOTS];
	logic [IDX_W-1:0] stack_mem [SLOTS];

	logic [gha_pkg::FUNC_W-1:0] func_q;
	logic [IDX_W-1:0]           idx_q;
	logic [GEN_W-1:0]           gen_q;
	logic [IDX_W-1:0]           slot_q;
	logic [IDX_W-1:0]           stk_rdata_q;
	logic [GEN_W:0]             slot_rdata_q;

	logic [CNT_W-1:0] free_top_q;
	logic [CNT_W-1:0] high_water_q;
	logic [CNT_W-1:0] live_q;

	logic                         rsp_valid_q;
	logic [gha_pkg::STATUS_W-1:0] rsp_status_q;
	logic [IDX_W-1:0]             rsp_index_q;
	logic [GEN_W-1:0]             rsp_gen_q;
	logic [CNT_W-1:0]             rsp_live_q;

	logic             in_fire;
	logic             out_free;
	logic             commit;
	logic [CNT_W-1:0] top_m1;
	logic [IDX_W-1:0] slot_sel;

	logic                         rd_used;
	logic [GEN_W-1:0]             rd_gen;
	logic [GEN_W-1:0]             gen_inc;
	logic                         alive;
	logic [gha_pkg::STATUS_W-1:0] st_n;
	logic [IDX_W-1:0]             o_idx;
	logic [GEN_W-1:0]             o_gen;
	logic                         slot_we;
	logic [GEN_W:0]               slot_wd;
	logic                         stk_we;
	logic [CNT_W-1:0]             top_n;
	logic [CNT_W-1:0]             hw_n;
	logic [CNT_W-1:0]             live_n;

	assign req.ready = (state_q == S_IDLE);
	assign in_fire   = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign commit    = (state_q == S_EXEC) && out_free;
	assign top_m1    = free_top_q - CNT_W'(1);

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.slot_index      = rsp_index_q;
	assign rsp.slot_generation = rsp_gen_q;
	assign rsp.live_total      = rsp_live_q;

	// slot address: stack top, then the next fresh slot, else the handle's own index
	always_comb begin
		if (func_q == gha_pkg::OP_ALLOC) begin
			slot_sel = (free_top_q != '0) ? stk_rdata_q : high_water_q[IDX_W-1:0];
		end else begin
			slot_sel = idx_q;
		end
	end

	assign rd_used = slot_rdata_q[GEN_W];
	assign rd_gen  = slot_rdata_q[GEN_W-1:0];
	assign gen_inc = (rd_gen + GEN_W'(1) == '0) ? GEN_W'(1) : rd_gen + GEN_W'(1);
	assign alive   = (gen_q != '0) && (CNT_W'(idx_q) < high_water_q) && rd_used &&
		(rd_gen == gen_q);

	always_comb begin
		st_n    = gha_pkg::ST_OK;
		o_idx   = idx_q;
		o_gen   = gen_q;
		slot_we = 1'b0;
		slot_wd = '0;
		stk_we  = 1'b0;
		top_n   = free_top_q;
		hw_n    = high_water_q;
		live_n  = live_q;
		case (func_q)
			gha_pkg::OP_ALLOC: begin
				if (free_top_q != '0) begin
					top_n   = top_m1;
					slot_we = 1'b1;
					slot_wd = {1'b1, rd_gen};
					o_idx   = slot_q;
					o_gen   = rd_gen;
					live_n  = live_q + CNT_W'(1);
				end else if (high_water_q < CNT_W'(SLOTS)) begin
					hw_n    = high_water_q + CNT_W'(1);
					slot_we = 1'b1;
					slot_wd = {1'b1, GEN_W'(1)};
					o_idx   = slot_q;
					o_gen   = GEN_W'(1);
					live_n  = live_q + CNT_W'(1);
				end else begin
					st_n  = gha_pkg::ST_FULL;
					o_idx = '0;
					o_gen = '0;
				end
			end
			gha_pkg::OP_RELEASE: begin
				if (alive) begin
					slot_we = 1'b1;
					slot_wd = {1'b0, gen_inc};
					if (free_top_q < CNT_W'(SLOTS)) begin
						stk_we = 1'b1;
						top_n  = free_top_q + CNT_W'(1);
					end
					if (live_q != '0) begin
						live_n = live_q - CNT_W'(1);
					end
				end else begin
					st_n = gha_pkg::ST_DEAD;
				end
			end
			gha_pkg::OP_CHECK: begin
				st_n = alive ? gha_pkg::ST_OK : gha_pkg::ST_DEAD;
			end
			default: begin
				st_n = gha_pkg::ST_DEAD;
			end
		endcase
	end

	// free stack: read at accept, pushed at commit
	always_ff @(posedge clk) begin
		if (in_fire) begin
			stk_rdata_q <= stack_mem[top_m1[IDX_W-1:0]];
		end
		if (commit && stk_we) begin
			stack_mem[free_top_q[IDX_W-1:0]] <= idx_q;
		end
	end

	// slot table: read in the address step, written back at commit
	always_ff @(posedge clk) begin
		if (state_q == S_ADDR) begin
			slot_rdata_q <= slot_mem[slot_sel];
		end
		if (commit && slot_we) begin
			slot_mem[slot_q] <= slot_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_q <= req.func;
			idx_q  <= req.handle_index;
			gen_q  <= req.handle_generation;
		end
		if (state_q == S_ADDR) begin
			slot_q <= slot_sel;
		end
		if (commit) begin
			rsp_status_q <= st_n;
			rsp_index_q  <= o_idx;
			rsp_gen_q    <= o_gen;
			rsp_live_q   <= live_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			free_top_q   <= '0;
			high_water_q <= '0;
			live_q       <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_ADDR;
					end
				end
				S_ADDR: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (out_free) begin
						free_top_q   <= top_n;
						high_water_q <= hw_n;
						live_q       <= live_n;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/gha_checker.sv
// Port-level checker for the generational handle allocator, with its bind.
// Depends on gha_pkg and generational_handle_allocator_macros.svh.
`include "generational_handle_allocator_macros.svh"

module gha_checker #(
	parameter int SLOTS = gha_pkg::SLOTS_DEFAULT,
	parameter int IDX_W = 10,
	parameter int CNT_W = 11
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [gha_pkg::STATUS_W-1:0] rsp_status,
	input logic [IDX_W-1:0]             rsp_slot_index,
	input logic [gha_pkg::GEN_W-1:0]    rsp_slot_generation,
	input logic [CNT_W-1:0]             rsp_live_total
);

	logic [gha_pkg::STATUS_W+IDX_W+gha_pkg::GEN_W+CNT_W-1:0] rsp_payload;
	logic stalled;
	logic is_full;
	logic full_zero;
	logic code_ok;

	assign rsp_payload = {rsp_status, rsp_slot_index, rsp_slot_generation, rsp_live_total};
	assign stalled     = rsp_valid && !rsp_ready;
	assign is_full     = rsp_valid && (rsp_status == gha_pkg::ST_FULL);
	assign full_zero   = (rsp_slot_index == '0) && (rsp_slot_generation == '0);
	assign code_ok     = rsp_status inside {gha_pkg::ST_OK, gha_pkg::ST_FULL, gha_pkg::ST_DEAD};

	`GHA_ASSERT_NEXT(a_rsp_hold, stalled, rsp_valid && $stable(rsp_payload))
	`GHA_ASSERT_IMPL(a_live_bound, rsp_valid, rsp_live_total <= CNT_W'(SLOTS))
	`GHA_ASSERT_IMPL(a_full_zero, is_full, full_zero)
	`GHA_ASSERT_IMPL(a_status_code, rsp_valid, code_ok)

endmodule

bind generational_handle_allocator gha_checker #(
	.SLOTS (SLOTS),
	.IDX_W (IDX_W),
	.CNT_W (CNT_W)
) u_gha_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.rsp_status          (rsp.status),
	.rsp_slot_index      (rsp.slot_index),
	.rsp_slot_generation (rsp.slot_generation),
	.rsp_live_total      (rsp.live_total)
);
